// ----- hdl/rbvi_pkg.sv -----
package rbvi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUO_W         = 32;
    localparam int STEP_W        = 16;
    localparam int VAL_W         = 32;
    localparam int UMAG_W        = 31;
    localparam int CFG_IDX_W     = 2;

    localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd1092;
    localparam logic [VAL_W-1:0]  GRAVITY_X_RST = 32'sd0;
    localparam logic [VAL_W-1:0]  GRAVITY_Y_RST = -32'sd642252;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TIME = 2'd0,
        CFG_GRAVITY_X = 2'd1,
        CFG_GRAVITY_Y = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } rbvi_sign_t;

endpackage

// ----- hdl/rbvi_divider.sv -----
module rbvi_divider import rbvi_pkg::*; #(
    parameter int DW = 33
) (
    input  logic              clk,
    input  logic              en,
    input  logic [DW-1:0]     rem_in,
    input  logic [DW-1:0]     div_in,
    input  logic [QUO_W-1:0]  nlo_in,
    input  rbvi_sign_t        sign_in,
    output logic [QUO_W-1:0]  quo,
    output rbvi_sign_t        sign_out
);

    logic [DW-1:0]    r_reg [QUO_W];
    logic [DW-1:0]    d_reg [QUO_W];
    logic [QUO_W-1:0] n_reg [QUO_W];
    logic [QUO_W-1:0] q_reg [QUO_W];
    rbvi_sign_t       s_reg [QUO_W];

    logic [DW-1:0]    r_prev [QUO_W];
    logic [DW-1:0]    d_prev [QUO_W];
    logic [QUO_W-1:0] n_prev [QUO_W];
    logic [QUO_W-1:0] q_prev [QUO_W];
    rbvi_sign_t       s_prev [QUO_W];

    logic [DW-1:0]    r_next [QUO_W];
    logic [QUO_W-1:0] n_next [QUO_W];
    logic [QUO_W-1:0] q_next [QUO_W];

    always_comb
    begin
        r_prev[0] = rem_in;
        d_prev[0] = div_in;
        n_prev[0] = nlo_in;
        q_prev[0] = '0;
        s_prev[0] = sign_in;
        for (int k = 1; k < QUO_W; k++)
        begin
            r_prev[k] = r_reg[k-1];
            d_prev[k] = d_reg[k-1];
            n_prev[k] = n_reg[k-1];
            q_prev[k] = q_reg[k-1];
            s_prev[k] = s_reg[k-1];
        end
    end

    // one quotient bit per stage, restoring
    always_comb
    begin
        logic [DW:0] trial;
        for (int k = 0; k < QUO_W; k++)
        begin
            trial = {r_prev[k], n_prev[k][QUO_W-1]};
            if (trial >= {1'b0, d_prev[k]})
            begin
                r_next[k] = DW'(trial - {1'b0, d_prev[k]});
                q_next[k] = {q_prev[k][QUO_W-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = DW'(trial);
                q_next[k] = {q_prev[k][QUO_W-2:0], 1'b0};
            end
            n_next[k] = n_prev[k] << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                r_reg[k] <= r_next[k];
                d_reg[k] <= d_prev[k];
                n_reg[k] <= n_next[k];
                q_reg[k] <= q_next[k];
                s_reg[k] <= s_prev[k];
            end
        end
    end

    assign quo      = q_reg[QUO_W-1];
    assign sign_out = s_reg[QUO_W-1];

endmodule

// ----- hdl/rigid_body_velocity_integrator.sv -----
// pipeline from input request to result: 5 arithmetic stages,
// 32 divider stages, one output register
// throughput: one body per cycle; a stalled output holds the whole pipeline
// reset: rst_n clears all valid bits and loads step_time 1092, gravity_x 0,
// gravity_y -642252; no clearing pass
module rigid_body_velocity_integrator import rbvi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // lin_vel_x, lin_vel_y, ang_vel, force_x, force_y, torque_in, inv_mass,
    // inv_inertia, gravity_scale, lin_damping, ang_damping, zero pad
    input  logic [351:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // new_lin_vel_x, new_lin_vel_y, new_ang_vel
    output logic [95:0]          m_axis_tdata,
    // saturated
    output logic                 m_axis_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int AW  = 65 - F;
    localparam int VW  = 83 - 2*F;
    localparam int DW  = ((48 - F) > (F + 1) ? (48 - F) : (F + 1)) + 1;
    localparam int CW  = VW + DW + QUO_W;
    localparam int SH  = QUO_W - F;
    localparam int LAT = 5 + QUO_W + 1;
    localparam int PW  = STEP_W + UMAG_W;

    logic [STEP_W-1:0]       step_time_reg;
    logic signed [VAL_W-1:0] gravity_x_reg, gravity_y_reg;
    logic [LAT-1:0]          vld_reg;
    logic                    adv;

    assign adv           = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= STEP_TIME_RST;
            gravity_x_reg <= GRAVITY_X_RST;
            gravity_y_reg <= GRAVITY_Y_RST;
            vld_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STEP_TIME: step_time_reg <= cfg_data[STEP_W-1:0];
                    CFG_GRAVITY_X: gravity_x_reg <= cfg_data;
                    CFG_GRAVITY_Y: gravity_y_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (adv)
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // input fields
    logic signed [VAL_W-1:0] in_vx, in_vy, in_w, in_fx, in_fy, in_tq, in_gs;
    logic [UMAG_W-1:0]       in_im, in_ii, in_ld, in_ad;

    assign in_vx = s_axis_tdata[31:0];
    assign in_vy = s_axis_tdata[63:32];
    assign in_w  = s_axis_tdata[95:64];
    assign in_fx = s_axis_tdata[127:96];
    assign in_fy = s_axis_tdata[159:128];
    assign in_tq = s_axis_tdata[191:160];
    assign in_im = s_axis_tdata[222:192];
    assign in_ii = s_axis_tdata[253:223];
    assign in_gs = s_axis_tdata[285:254];
    assign in_ld = s_axis_tdata[316:286];
    assign in_ad = s_axis_tdata[347:317];

    // stage 1: products
    logic signed [63:0]      p_gx_reg, p_gy_reg, p_fx_reg, p_fy_reg, p_tq_reg;
    logic [PW-1:0]           p_dl_reg, p_da_reg;
    logic                    im_nz_reg, ii_nz_reg;
    logic signed [VAL_W-1:0] s1_vx_reg, s1_vy_reg, s1_w_reg;

    // stage 2: accelerations and divisors
    logic signed [AW-1:0]    ax_reg, ay_reg, aw_reg;
    logic [DW-1:0]           s2_dl_reg, s2_da_reg;
    logic signed [VAL_W-1:0] s2_vx_reg, s2_vy_reg, s2_w_reg;

    // stage 3: velocity change
    logic signed [VW-1:0]    dvx_reg, dvy_reg, dvw_reg;
    logic [DW-1:0]           s3_dl_reg, s3_da_reg;
    logic signed [VAL_W-1:0] s3_vx_reg, s3_vy_reg, s3_w_reg;

    // stage 4: undamped velocity
    logic signed [VW-1:0]    s4_vx_reg, s4_vy_reg, s4_w_reg;
    logic [DW-1:0]           s4_dl_reg, s4_da_reg;

    // stage 5: magnitude, overflow check, divider set-up
    logic [DW-1:0]           r0_reg [3];
    logic [DW-1:0]           d5_reg [3];
    logic [QUO_W-1:0]        n5_reg [3];
    rbvi_sign_t              sg5_reg [3];

    logic signed [AW+16:0]   sp_x, sp_y, sp_w;
    logic signed [STEP_W:0]  dt_s;
    logic signed [VW-1:0]    v4 [3];
    logic [DW-1:0]           d4 [3];
    logic [VW-1:0]           mag [3];
    logic                    neg [3];

    assign dt_s = $signed({1'b0, step_time_reg});
    assign sp_x = ax_reg * dt_s;
    assign sp_y = ay_reg * dt_s;
    assign sp_w = aw_reg * dt_s;

    assign v4[0] = s4_vx_reg;
    assign v4[1] = s4_vy_reg;
    assign v4[2] = s4_w_reg;
    assign d4[0] = s4_dl_reg;
    assign d4[1] = s4_dl_reg;
    assign d4[2] = s4_da_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            neg[j] = v4[j] < 0;
            mag[j] = neg[j] ? VW'(-v4[j]) : VW'(v4[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_gx_reg  <= in_gs * gravity_x_reg;
            p_gy_reg  <= in_gs * gravity_y_reg;
            p_fx_reg  <= in_fx * $signed({1'b0, in_im});
            p_fy_reg  <= in_fy * $signed({1'b0, in_im});
            p_tq_reg  <= in_tq * $signed({1'b0, in_ii});
            p_dl_reg  <= PW'(step_time_reg) * PW'(in_ld);
            p_da_reg  <= PW'(step_time_reg) * PW'(in_ad);
            im_nz_reg <= in_im != '0;
            ii_nz_reg <= in_ii != '0;
            s1_vx_reg <= in_vx;
            s1_vy_reg <= in_vy;
            s1_w_reg  <= in_w;

            ax_reg    <= im_nz_reg ? AW'((p_gx_reg >>> F) + (p_fx_reg >>> F)) : '0;
            ay_reg    <= im_nz_reg ? AW'((p_gy_reg >>> F) + (p_fy_reg >>> F)) : '0;
            aw_reg    <= ii_nz_reg ? AW'(p_tq_reg >>> F) : '0;
            s2_dl_reg <= (DW'(1) << F) + DW'(p_dl_reg >> F);
            s2_da_reg <= (DW'(1) << F) + DW'(p_da_reg >> F);
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_w_reg  <= s1_w_reg;

            dvx_reg   <= VW'(sp_x >>> F);
            dvy_reg   <= VW'(sp_y >>> F);
            dvw_reg   <= VW'(sp_w >>> F);
            s3_dl_reg <= s2_dl_reg;
            s3_da_reg <= s2_da_reg;
            s3_vx_reg <= s2_vx_reg;
            s3_vy_reg <= s2_vy_reg;
            s3_w_reg  <= s2_w_reg;

            s4_vx_reg <= VW'(s3_vx_reg) + dvx_reg;
            s4_vy_reg <= VW'(s3_vy_reg) + dvy_reg;
            s4_w_reg  <= VW'(s3_w_reg) + dvw_reg;
            s4_dl_reg <= s3_dl_reg;
            s4_da_reg <= s3_da_reg;

            for (int j = 0; j < 3; j++)
            begin
                // quotient of 2^32 or more cannot fit, flag it up front
                sg5_reg[j].ovf <= CW'(mag[j]) >= (CW'(d4[j]) << SH);
                sg5_reg[j].neg <= neg[j];
                r0_reg[j]      <= DW'(mag[j] >> SH);
                n5_reg[j]      <= QUO_W'(CW'(mag[j]) << F);
                d5_reg[j]      <= d4[j];
            end
        end
    end

    logic [QUO_W-1:0] quo [3];
    rbvi_sign_t       sgq [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        rbvi_divider #(
            .DW (DW)
        ) u_div (
            .clk      (clk),
            .en       (adv),
            .rem_in   (r0_reg[g]),
            .div_in   (d5_reg[g]),
            .nlo_in   (n5_reg[g]),
            .sign_in  (sg5_reg[g]),
            .quo      (quo[g]),
            .sign_out (sgq[g])
        );
    end

    // saturation to signed 32 bits
    logic [VAL_W-1:0] res [3];
    logic [2:0]       clip;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (sgq[j].neg)
            begin
                clip[j] = sgq[j].ovf || (quo[j] > 32'h8000_0000);
                res[j]  = clip[j] ? 32'h8000_0000 : VAL_W'(-quo[j]);
            end
            else
            begin
                clip[j] = sgq[j].ovf || quo[j][QUO_W-1];
                res[j]  = clip[j] ? 32'h7FFF_FFFF : quo[j];
            end
        end
    end

    logic [95:0] out_data_reg;
    logic        out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {res[2], res[1], res[0]};
            out_sat_reg  <= |clip;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_sat_reg;

endmodule
